>>> hw/rtl/cstc_pkg.sv
// Shared types and constants of the context-switch trace capture block.
package cstc_pkg;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STAMP_W   = 20;
  localparam int unsigned THR_W     = 6;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned XCNT_O_W  = 7;
  localparam int unsigned REC_W     = STAMP_W + 2 * THR_W;

  typedef enum logic [FUNC_W-1:0] {
    F_SWITCH    = 3'd0,
    F_EXIT      = 3'd1,
    F_ARM       = 3'd2,
    F_REARM     = 3'd3,
    F_READ_LOG  = 3'd4,
    F_READ_EXIT = 3'd5
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Packed trace record: time in the top bits, then outgoing and incoming thread.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [THR_W-1:0]   out_thr;
    logic [THR_W-1:0]   in_thr;
  } record_t;

  // One result word.
  typedef struct packed {
    logic                record_written;
    logic                entry_valid;
    logic [STAMP_W-1:0]  entry_time;
    logic [THR_W-1:0]    entry_out;
    logic [THR_W-1:0]    entry_in;
    logic [CNT_W-1:0]    entry_count;
    logic [THR_W-1:0]    exited_thread;
    logic [XCNT_O_W-1:0] exited_count;
    logic                is_triggered;
    logic                capturing;
    logic [TIME_W-1:0]   trigger_stamp;
  } res_t;

endpackage

>>> hw/rtl/context_switch_trace_capture_core.sv
// The result word is registered at commit in EXEC; commit waits while the last result is stalled.
// A new word is taken only in IDLE, after the previous word has committed; each word does one
// trace-memory read at accept and one read-modify-write commit in EXEC.
// Reset (rst_ni low, async): control, pointers, counters and trigger state clear at once.
// Trace and exited-thread memories are not cleared; nothing reads an entry before it is written.
module context_switch_trace_capture_core
  import cstc_pkg::*;
#(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned EXITED_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [TIME_W-1:0]   now_time_i,
  input  logic [THR_W-1:0]    in_thread_i,
  input  logic [THR_W-1:0]    out_thread_i,
  input  logic                in_logged_i,
  input  logic                out_logged_i,
  input  logic [IDX_W-1:0]    read_index_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                record_written_o,
  output logic                entry_valid_o,
  output logic [STAMP_W-1:0]  entry_time_o,
  output logic [THR_W-1:0]    entry_out_o,
  output logic [THR_W-1:0]    entry_in_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic [THR_W-1:0]    exited_thread_o,
  output logic [XCNT_O_W-1:0] exited_count_o,
  output logic                is_triggered_o,
  output logic                capturing_o,
  output logic [TIME_W-1:0]   trigger_stamp_o
);

  // Widths of log and ring pointers, counts and wrapped-sum address math.
  localparam int unsigned LIDX_W = $clog2(LOG_DEPTH);
  localparam int unsigned LCNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned LSUM_W = ((LIDX_W > IDX_W) ? LIDX_W : IDX_W) + 1;
  localparam int unsigned XIDX_W = $clog2(EXITED_DEPTH);
  localparam int unsigned XCNT_W = $clog2(EXITED_DEPTH + 1);
  localparam int unsigned XSUM_W = ((XIDX_W > IDX_W) ? XIDX_W : IDX_W) + 1;
  localparam int unsigned HALF   = LOG_DEPTH / 2;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [LIDX_W-1:0]   slot_q, slot_d;        // next trace slot to write
  logic                wrapped_q, wrapped_d;  // log has wrapped at least once
  logic                armed_q, armed_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;      // time of arming
  logic [LCNT_W-1:0]   post_q, post_d;        // records left after trigger
  logic [XIDX_W-1:0]   head_q, head_d;        // exited ring push pointer
  logic [XIDX_W-1:0]   tail_q, tail_d;        // exited ring oldest entry
  logic [XCNT_W-1:0]   total_q, total_d;      // exited ring fill
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  // Held input word (payload, no reset)
  func_e               func_q;
  logic [TIME_W-1:0]   now_q;
  logic [THR_W-1:0]    in_thr_q;
  logic [THR_W-1:0]    out_thr_q;
  logic                in_log_q;
  logic                out_log_q;
  logic [IDX_W-1:0]    idx_q;

  logic in_accept;
  logic commit;

  // ---------------------------------------------------------------------------
  // FSM: IDLE takes a word and issues the memory reads, EXEC commits it
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: commit     = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Read addresses, formed at accept from the incoming word
  // ---------------------------------------------------------------------------
  logic [LSUM_W-1:0] log_sum;
  logic [LIDX_W-1:0] log_raddr;
  logic [LIDX_W-1:0] trace_raddr;
  logic [XSUM_W-1:0] x_sum;
  logic [XIDX_W-1:0] ring_raddr;

  // Oldest entry sits at the write slot once wrapped, else at slot zero.
  assign log_sum = LSUM_W'(wrapped_q ? slot_q : '0) + LSUM_W'(read_index_i);
  assign log_raddr = (log_sum >= LSUM_W'(LOG_DEPTH)) ?
                     LIDX_W'(log_sum - LSUM_W'(LOG_DEPTH)) : LIDX_W'(log_sum);
  // Record writes need the old record at the write slot for the retire check.
  assign trace_raddr = (func_e'(func_i) == F_READ_LOG) ? log_raddr : slot_q;

  assign x_sum = XSUM_W'(tail_q) + XSUM_W'(read_index_i);
  assign ring_raddr = (x_sum >= XSUM_W'(EXITED_DEPTH)) ?
                      XIDX_W'(x_sum - XSUM_W'(EXITED_DEPTH)) : XIDX_W'(x_sum);

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic              trace_we;
  record_t           trace_wdata;
  logic [REC_W-1:0]  trace_rdata;
  record_t           old_rec;
  logic              ring_we;
  logic [THR_W-1:0]  ring_rdata;

  cstc_ram #(
    .WIDTH (REC_W),
    .DEPTH (LOG_DEPTH)
  ) u_trace_ram (
    .clk_i   (clk_i),
    .we_i    (trace_we),
    .waddr_i (slot_q),
    .wdata_i (trace_wdata),
    .re_i    (in_accept),
    .raddr_i (trace_raddr),
    .rdata_o (trace_rdata)
  );

  cstc_ram #(
    .WIDTH (THR_W),
    .DEPTH (EXITED_DEPTH)
  ) u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_q),
    .wdata_i (out_thr_q),
    .re_i    (in_accept),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign old_rec = record_t'(trace_rdata);

  // ---------------------------------------------------------------------------
  // Commit: read-modify-write of the control state and memories
  // ---------------------------------------------------------------------------
  logic              cap_now;
  logic              put;
  logic              retire;
  logic              push;
  logic [LCNT_W-1:0] count_q;
  logic [LCNT_W-1:0] count_d;

  assign cap_now = armed_q ? (post_q != '0) : 1'b1;
  assign count_q = wrapped_q ? LCNT_W'(LOG_DEPTH) : LCNT_W'(slot_q);

  always_comb begin
    put = 1'b0;
    unique case (func_q)
      F_SWITCH: put = cap_now && (in_log_q || out_log_q);
      F_EXIT:   put = total_q < XCNT_W'(EXITED_DEPTH);
      default:  put = 1'b0;
    endcase
  end

  // An overwritten record with equal threads is an exit record: drop its ring entry.
  assign retire = put && wrapped_q && (old_rec.out_thr == old_rec.in_thr) && (total_q != '0);
  assign push   = put && (func_q == F_EXIT);

  assign trace_wdata.stamp   = now_q[STAMP_W-1:0];
  assign trace_wdata.out_thr = out_thr_q;
  assign trace_wdata.in_thr  = (func_q == F_EXIT) ? out_thr_q : in_thr_q;
  assign trace_we = commit && put;
  assign ring_we  = commit && push;

  always_comb begin
    slot_d    = slot_q;
    wrapped_d = wrapped_q;
    armed_d   = armed_q;
    stamp_d   = stamp_q;
    post_d    = post_q;
    head_d    = head_q;
    tail_d    = tail_q;
    total_d   = total_q;
    if (commit) begin
      if (put) begin
        if (slot_q == LIDX_W'(LOG_DEPTH - 1)) begin
          slot_d    = '0;
          wrapped_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        if (armed_q && (post_q != '0)) begin
          post_d = post_q - 1'b1;
        end
      end
      if (retire) begin
        tail_d = (tail_q == XIDX_W'(EXITED_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (push) begin
        head_d = (head_q == XIDX_W'(EXITED_DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (retire && !push) begin
        total_d = total_q - 1'b1;
      end else if (push && !retire) begin
        total_d = total_q + 1'b1;
      end
      if ((func_q == F_ARM) && !armed_q) begin
        armed_d = 1'b1;
        stamp_d = now_q;
        // Never wrapped and at most half full: allow the rest of the buffer.
        if (!wrapped_q && (LCNT_W'(slot_q) <= LCNT_W'(HALF))) begin
          post_d = LCNT_W'(LOG_DEPTH) - LCNT_W'(slot_q);
        end else begin
          post_d = LCNT_W'(HALF);
        end
      end
      if ((func_q == F_REARM) && armed_q) begin
        armed_d   = 1'b0;
        stamp_d   = '0;
        post_d    = '0;
        slot_d    = '0;
        wrapped_d = 1'b0;
        head_d    = '0;
        tail_d    = '0;
        total_d   = '0;
      end
    end
  end

  assign count_d = wrapped_d ? LCNT_W'(LOG_DEPTH) : LCNT_W'(slot_d);

  // Result word, built from post-step state
  always_comb begin
    res_d                = '0;
    res_d.record_written = put;
    res_d.entry_count    = CNT_W'(count_d);
    res_d.exited_count   = XCNT_O_W'(total_d);
    res_d.is_triggered   = armed_d;
    res_d.capturing      = armed_d ? (post_d != '0) : 1'b1;
    res_d.trigger_stamp  = armed_d ? stamp_d : '0;
    if ((func_q == F_READ_LOG) && (LSUM_W'(idx_q) < LSUM_W'(count_q))) begin
      res_d.entry_valid = 1'b1;
      res_d.entry_time  = old_rec.stamp;
      res_d.entry_out   = old_rec.out_thr;
      res_d.entry_in    = old_rec.in_thr;
    end
    if ((func_q == F_READ_EXIT) && (XSUM_W'(idx_q) < XSUM_W'(total_q))) begin
      res_d.entry_valid   = 1'b1;
      res_d.exited_thread = ring_rdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      wrapped_q   <= 1'b0;
      armed_q     <= 1'b0;
      stamp_q     <= '0;
      post_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      wrapped_q   <= wrapped_d;
      armed_q     <= armed_d;
      stamp_q     <= stamp_d;
      post_q      <= post_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q    <= func_e'(func_i);
      now_q     <= now_time_i;
      in_thr_q  <= in_thread_i;
      out_thr_q <= out_thread_i;
      in_log_q  <= in_logged_i;
      out_log_q <= out_logged_i;
      idx_q     <= read_index_i;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_valid_o      = out_valid_q;
  assign record_written_o = res_q.record_written;
  assign entry_valid_o    = res_q.entry_valid;
  assign entry_time_o     = res_q.entry_time;
  assign entry_out_o      = res_q.entry_out;
  assign entry_in_o       = res_q.entry_in;
  assign entry_count_o    = res_q.entry_count;
  assign exited_thread_o  = res_q.exited_thread;
  assign exited_count_o   = res_q.exited_count;
  assign is_triggered_o   = res_q.is_triggered;
  assign capturing_o      = res_q.capturing;
  assign trigger_stamp_o  = res_q.trigger_stamp;

endmodule

>>> hw/rtl/cstc_ram.sv
// Simple dual-port synchronous RAM, one write port and one registered read port.
module cstc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cstc_checker.sv
// Port-level checker for the trace capture core, bound to the top level.
module cstc_checker
  import cstc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STAMP_W-1:0]  entry_time_o,
  input logic [CNT_W-1:0]    entry_count_o,
  input logic                is_triggered_o,
  input logic                capturing_o,
  input logic [TIME_W-1:0]   trigger_stamp_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_time_o)
      && $stable(entry_count_o))
    else $error("result word changed under stall");

  // One word at a time: no accept in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous word in flight");

  // Untriggered capture always runs.
  a_free_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_triggered_o |-> capturing_o && (trigger_stamp_o == '0))
    else $error("capture stopped or stamp set without trigger");

  // A nonzero stamp only while triggered.
  a_stamp_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trigger_stamp_o != '0) |-> is_triggered_o)
    else $error("trigger stamp without trigger");

endmodule

bind context_switch_trace_capture_core cstc_checker u_cstc_checker (.*);
